// ===== rtl/gtpc_pkg.sv =====
package gtpc_pkg;

  // Accumulator width; the datapath widths below follow from it
  localparam int ANGLE_BITS = 40;
  localparam int ERR_W      = ANGLE_BITS + 1;
  localparam int RATE_W     = 16;
  localparam int TICK_W     = 10;
  localparam int RT_W       = RATE_W + TICK_W + 1;
  localparam int GAIN_W     = 12;
  localparam int BAND_W     = 15;
  localparam int POWER_W    = 7;
  localparam int TARGET_W   = 11;
  localparam int SETTLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed-point alignment: angle units are 2^-18 degree
  localparam int TGT_SHIFT  = 18;
  localparam int BAND_SHIFT = 10;
  localparam int GAIN_SHIFT = 26;

  // Gain multiply is split into a low and a high partial product
  localparam int HALF_W = (ANGLE_BITS + 1) / 2;
  localparam int HI_W   = ANGLE_BITS - HALF_W;
  localparam int PROD_W = ANGLE_BITS + GAIN_W;
  localparam int Q_W    = PROD_W - GAIN_SHIFT;

  // Request codes
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd5;

  // Register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST  = 11'd0;
  localparam logic [GAIN_W-1:0]   GAIN_RST    = 12'd333;
  localparam logic [BAND_W-1:0]   BAND_RST    = 15'd1280;
  localparam logic [POWER_W-1:0]  FLOOR_RST   = 7'd60;
  localparam logic [POWER_W-1:0]  CEILING_RST = 7'd65;
  localparam logic [SETTLE_W-1:0] SETTLE_RST  = 16'd512;

  // Datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_RATE,
    OP_ACCUM,
    OP_ERROR,
    OP_ABS,
    OP_BAND,
    OP_DECIDE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_CLAMP,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    BR_NEVER,
    BR_ALWAYS,
    BR_NO_ITEM,
    BR_IS_START,
    BR_NO_POWER,
    BR_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  // Program addresses
  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_DECODE = 4'd1;
  localparam step_t S_ACCUM  = 4'd2;
  localparam step_t S_ERROR  = 4'd3;
  localparam step_t S_ABS    = 4'd4;
  localparam step_t S_BAND   = 4'd5;
  localparam step_t S_DECIDE = 4'd6;
  localparam step_t S_MUL_LO = 4'd7;
  localparam step_t S_MUL_HI = 4'd8;
  localparam step_t S_SUM    = 4'd9;
  localparam step_t S_CLAMP  = 4'd10;
  localparam step_t S_EMIT   = 4'd11;
  localparam step_t S_RETURN = 4'd12;
  localparam step_t S_START  = 4'd13;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Control store: a taken jump goes to target, otherwise to the next step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t cw;
    unique case (s)
      S_WAIT:   cw = '{OP_NOP,      BR_NO_ITEM,  S_WAIT};
      S_DECODE: cw = '{OP_MUL_RATE, BR_IS_START, S_START};
      S_ACCUM:  cw = '{OP_ACCUM,    BR_NEVER,    S_WAIT};
      S_ERROR:  cw = '{OP_ERROR,    BR_NEVER,    S_WAIT};
      S_ABS:    cw = '{OP_ABS,      BR_NEVER,    S_WAIT};
      S_BAND:   cw = '{OP_BAND,     BR_NEVER,    S_WAIT};
      S_DECIDE: cw = '{OP_DECIDE,   BR_NO_POWER, S_EMIT};
      S_MUL_LO: cw = '{OP_MUL_LO,   BR_NEVER,    S_WAIT};
      S_MUL_HI: cw = '{OP_MUL_HI,   BR_NEVER,    S_WAIT};
      S_SUM:    cw = '{OP_SUM,      BR_NEVER,    S_WAIT};
      S_CLAMP:  cw = '{OP_CLAMP,    BR_NEVER,    S_WAIT};
      S_EMIT:   cw = '{OP_EMIT,     BR_OUT_BUSY, S_EMIT};
      S_RETURN: cw = '{OP_NOP,      BR_ALWAYS,   S_WAIT};
      S_START:  cw = '{OP_CLEAR,    BR_ALWAYS,   S_EMIT};
      default:  cw = '{OP_NOP,      BR_ALWAYS,   S_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/gyro_turn_p_controller.sv =====
// Gyro turn controller: proportional drive with a deadband and a settle timer.
// Input words (in_valid / in_stall) carry req_type, turn_rate and elapsed_ticks.
// A start word clears the angle, the timer and the done latch; a sample word
// integrates the rate, forms the error to the setpoint and yields one drive
// word. Every input word yields exactly one output word (out_valid / out_stall)
// with drive_power, turn_done and within_band.
// A microcoded sequencer walks one word at a time through a shared datapath;
// in_stall is low only while the program waits at its first step.
// A start word runs the decode, clear and emit steps; an in-band sample runs
// decode, accumulate, error, abs, band, decide and emit; a sample that needs
// the gain multiply adds two partial products, sum and clamp before emit. A
// new word is taken only after its predecessor's result is loaded. The output
// register holds its word while out_stall is high; the program then waits at
// its emit step, and input stays stalled.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at any edge
// and must only be made while the block is idle.
// Synchronous reset restores register defaults and clears all turn state.
module gyro_turn_p_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gtpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtpc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic signed [gtpc_pkg::RATE_W-1:0]   turn_rate,
  input  logic [gtpc_pkg::TICK_W-1:0]          elapsed_ticks,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gtpc_pkg::POWER_W:0]    drive_power,
  output logic                                 turn_done,
  output logic                                 within_band
);
  import gtpc_pkg::*;

  localparam int AW = ANGLE_BITS;

  // Configuration registers
  logic [TARGET_W-1:0] target_degrees;
  logic [GAIN_W-1:0]   loop_gain;
  logic [BAND_W-1:0]   band_limit;
  logic [POWER_W-1:0]  power_floor;
  logic [POWER_W-1:0]  power_ceiling;
  logic [SETTLE_W-1:0] settle_ticks;

  // Sequencer
  step_t step, step_next;
  ctrl_t cw;
  logic  taken;
  logic  accept;
  logic  out_free;

  // Captured input word
  logic                     req_r;
  logic signed [RATE_W-1:0] rate_r;
  logic [TICK_W-1:0]        ticks_r;

  // Turn state
  logic signed [AW-1:0] angle_sum;
  logic [SETTLE_W-1:0]  settle_count;
  logic                 settle_armed;
  logic                 done_flag;

  // Working registers
  logic signed [RT_W-1:0]  rt_prod;
  logic signed [ERR_W-1:0] err;
  logic                    err_neg;
  logic [AW-1:0]           mag;
  logic                    inb_r;
  logic                    outb_r;
  logic [PROD_W-1:0]       acc;
  logic [HI_W+GAIN_W-1:0]  ph;
  logic signed [POWER_W:0] pwr;

  // Combinational datapath terms
  logic [AW:0]             acc_sum;
  logic [AW-1:0]           angle_next;
  logic signed [ERR_W-1:0] tgt_scaled;
  logic [ERR_W-1:0]        err_abs;
  logic [AW-1:0]           band_w;
  logic [SETTLE_W-1:0]     ticks_w;
  logic [HALF_W+GAIN_W-1:0] mul_lo;
  logic [HI_W+GAIN_W-1:0]  mul_hi;
  logic [Q_W-1:0]          q;
  logic [POWER_W-1:0]      mag_lim;
  logic                    inb_now;

  // Handshake
  assign in_stall = (step != S_WAIT);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Fetch the control word and resolve the jump
  always_comb begin
    cw = ucode(step);
    case (cw.cond)
      BR_NEVER:    taken = 1'b0;
      BR_ALWAYS:   taken = 1'b1;
      BR_NO_ITEM:  taken = !in_valid;
      BR_IS_START: taken = (req_r == REQ_START);
      BR_NO_POWER: taken = inb_r;
      BR_OUT_BUSY: taken = !out_free;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? cw.target : step + 4'd1;
  end

  // Saturating angle update
  always_comb begin
    acc_sum = {angle_sum[AW-1], angle_sum} + {{(AW+1-RT_W){rt_prod[RT_W-1]}}, rt_prod};
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      angle_next = acc_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      angle_next = acc_sum[AW-1:0];
    end
  end

  // Error, band and gain terms
  assign tgt_scaled = {{(ERR_W-TARGET_W-TGT_SHIFT){target_degrees[TARGET_W-1]}},
                       target_degrees, {TGT_SHIFT{1'b0}}};
  assign err_abs    = err[ERR_W-1] ? -err : err;
  assign band_w     = {{(AW-BAND_W-BAND_SHIFT){1'b0}}, band_limit, {BAND_SHIFT{1'b0}}};
  assign inb_now    = mag < band_w;
  assign ticks_w    = {{(SETTLE_W-TICK_W){1'b0}}, ticks_r};
  assign mul_lo     = (HALF_W+GAIN_W)'(mag[HALF_W-1:0]) * (HALF_W+GAIN_W)'(loop_gain);
  assign mul_hi     = (HI_W+GAIN_W)'(mag[AW-1:HALF_W]) * (HI_W+GAIN_W)'(loop_gain);
  assign q          = acc[PROD_W-1:GAIN_SHIFT];

  // Clamp to the ceiling, then lift small nonzero values to the floor
  always_comb begin
    if (q > {{(Q_W-POWER_W){1'b0}}, power_ceiling}) begin
      mag_lim = power_ceiling;
    end else if (q != '0 && q < {{(Q_W-POWER_W){1'b0}}, power_floor}) begin
      mag_lim = power_floor;
    end else begin
      mag_lim = q[POWER_W-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_degrees <= TARGET_RST;
      loop_gain      <= GAIN_RST;
      band_limit     <= BAND_RST;
      power_floor    <= FLOOR_RST;
      power_ceiling  <= CEILING_RST;
      settle_ticks   <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET:  target_degrees <= cfg_data[TARGET_W-1:0];
        REG_GAIN:    loop_gain      <= cfg_data[GAIN_W-1:0];
        REG_BAND:    band_limit     <= cfg_data[BAND_W-1:0];
        REG_FLOOR:   power_floor    <= cfg_data[POWER_W-1:0];
        REG_CEILING: power_ceiling  <= cfg_data[POWER_W-1:0];
        REG_SETTLE:  settle_ticks   <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= req_type;
      rate_r  <= turn_rate;
      ticks_r <= elapsed_ticks;
    end
  end

  // Step counter, turn state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= S_WAIT;
      angle_sum    <= '0;
      settle_count <= '0;
      settle_armed <= 1'b0;
      done_flag    <= 1'b0;
      inb_r        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      step <= step_next;

      // Drop the output word once it is taken, unless the emit step reloads it
      if (out_valid && !out_stall && cw.op != OP_EMIT) begin
        out_valid <= 1'b0;
      end

      unique case (cw.op)
        OP_NOP: ;
        OP_MUL_RATE: begin
          rt_prod <= RT_W'(rate_r) * RT_W'($signed({1'b0, ticks_r}));
        end
        OP_ACCUM: begin
          angle_sum <= angle_next;
        end
        OP_ERROR: begin
          err <= tgt_scaled - {angle_sum[AW-1], angle_sum};
          // Count the timer down, saturating at zero
          if (settle_armed) begin
            settle_count <= (settle_count > ticks_w) ? settle_count - ticks_w : '0;
          end
        end
        OP_ABS: begin
          err_neg <= err[ERR_W-1];
          mag     <= err_abs[AW-1:0];
        end
        OP_BAND: begin
          inb_r  <= inb_now;
          outb_r <= mag > band_w;
          // Arm the timer when the error first enters the band
          if (inb_now && !settle_armed) begin
            settle_count <= settle_ticks;
            settle_armed <= 1'b1;
          end
        end
        OP_DECIDE: begin
          pwr <= '0;
          if (settle_armed && settle_count == '0) begin
            if (outb_r) begin
              settle_armed <= 1'b0;
            end else if (inb_r) begin
              done_flag <= 1'b1;
            end
          end
        end
        OP_MUL_LO: begin
          acc <= {{(PROD_W-HALF_W-GAIN_W){1'b0}}, mul_lo};
        end
        OP_MUL_HI: begin
          ph <= mul_hi;
        end
        OP_SUM: begin
          acc <= acc + {ph, {HALF_W{1'b0}}};
        end
        OP_CLAMP: begin
          pwr <= err_neg ? -$signed({1'b0, mag_lim}) : $signed({1'b0, mag_lim});
        end
        OP_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            drive_power <= pwr;
            turn_done   <= done_flag;
            within_band <= inb_r;
          end
        end
        OP_CLEAR: begin
          angle_sum    <= '0;
          settle_count <= '0;
          settle_armed <= 1'b0;
          done_flag    <= 1'b0;
          inb_r        <= 1'b0;
          pwr          <= '0;
        end
        default: ;
      endcase
    end
  end

  // A disarmed timer always reads zero
  a_idle_timer_zero: assert property (@(posedge clk) disable iff (rst)
    !settle_armed |-> settle_count == '0)
    else $error("settle timer nonzero while disarmed");

  // The angle moves only on its accumulate or clear step
  a_angle_steps: assert property (@(posedge clk) disable iff (rst)
    !(step == S_ACCUM || step == S_START) |=> $stable(angle_sum))
    else $error("angle changed outside accumulate or clear");

  // A nonzero drive word never reports an in-band error
  a_power_band: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_power != '0 |-> !within_band)
    else $error("nonzero drive reported in band");

  // A new output word is loaded only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step == S_EMIT))
    else $error("output loaded outside emit step");

  // Input is taken only at the first step of the program
  a_take_at_wait: assert property (@(posedge clk) disable iff (rst)
    accept |=> step == S_DECODE)
    else $error("sequencer did not start decode after accept");

endmodule

// ===== test/gyro_turn_p_controller_tb.sv =====
module gyro_turn_p_controller_tb;
  import gtpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int IDLE_SETTLE    = 4;
  localparam int LONG_HOLD      = 150;
  localparam int PHASES         = 12;
  localparam int PHASE_WORDS    = 40;
  localparam int PLAN_ROWS      = 21;
  localparam int FULL_RUN       = 6;
  localparam int PROD_TB_W      = ANGLE_BITS + GAIN_W + 2;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 16'sh7FFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 16'sh8000;
  localparam logic [TICK_W-1:0]        TICK_MAX = 10'h3FF;

  // Wide enough for the angle plus one step, and for the error
  typedef logic signed [ANGLE_BITS+1:0] wide_t;

  typedef struct {
    logic signed [POWER_W:0] power;
    logic                    done;
    logic                    in_band;
  } drive_word_t;

  typedef struct packed {
    logic                    req;
    logic signed [RATE_W-1:0] rate;
    logic [TICK_W-1:0]       ticks;
    logic                    typed;
    logic signed [POWER_W:0] power;
    logic                    done;
    logic                    in_band;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      req_type;
  logic signed [RATE_W-1:0]  turn_rate;
  logic [TICK_W-1:0]         elapsed_ticks;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [POWER_W:0]   drive_power;
  logic                      turn_done;
  logic                      within_band;

  // Register mirror
  logic signed [TARGET_W-1:0] target_deg;
  logic [GAIN_W-1:0]          gain;
  logic [BAND_W-1:0]          band;
  logic [POWER_W-1:0]         floor_mag;
  logic [POWER_W-1:0]         ceil_mag;
  logic [SETTLE_W-1:0]        settle_len;

  // Turn state mirror
  logic signed [ANGLE_BITS-1:0] angle;
  logic [SETTLE_W-1:0]          settle_left;
  logic                         settle_armed;
  logic                         turn_settled;

  drive_word_t pending_drive_words[$];
  int  fail_count       = 0;
  int  idle_cycles      = 0;
  int  words_sent       = 0;
  bit  sender_quiet     = 1'b0;
  bit  receiver_quiet   = 1'b0;
  int  long_hold_asked  = 0;
  int  long_hold_served = 0;
  int  stall_left       = 0;
  int  run_left         = 0;

  // target, gain, band, floor, ceiling, settle
  int presets [6][6] = '{
    '{90, 333, 1280, 60, 65, 512},
    '{-720, 4095, 32767, 127, 127, 65535},
    '{1023, 0, 0, 0, 0, 0},
    '{-1024, 1, 100, 100, 20, 0},
    '{720, 2000, 256, 10, 127, 16},
    '{-45, 800, 4000, 127, 0, 40}
  };

  // Opening turns under the reset settings; typed rows carry their result
  plan_row_t plan [PLAN_ROWS] = '{
    '{REQ_START,  16'sd0,     10'd0,    1'b1, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, 16'sd0,     10'd0,    1'b1, 8'sd0,   1'b0, 1'b1},
    '{REQ_SAMPLE, 16'sd0,     TICK_MAX, 1'b1, 8'sd0,   1'b1, 1'b1},
    '{REQ_SAMPLE, RATE_MAX,   TICK_MAX, 1'b1, -8'sd65, 1'b1, 1'b0},
    '{REQ_SAMPLE, RATE_MIN,   TICK_MAX, 1'b1, 8'sd0,   1'b1, 1'b1},
    '{REQ_START,  RATE_MAX,   TICK_MAX, 1'b1, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, RATE_MIN,   TICK_MAX, 1'b1, 8'sd65,  1'b0, 1'b0},
    '{REQ_SAMPLE, RATE_MAX,   10'd0,    1'b1, 8'sd65,  1'b0, 1'b0},
    '{REQ_START,  RATE_MIN,   10'd0,    1'b1, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, 16'sd2560,  10'd512,  1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, 16'sd1,     10'd1,    1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, -16'sd2,    10'd1,    1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, 16'sd1,     10'd1,    1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, 16'sd0,     TICK_MAX, 1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, -16'sd1,    10'd1,    1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_START,  16'sd0,     10'd0,    1'b1, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, -16'sd2560, 10'd512,  1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, -16'sd1,    10'd1,    1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, 16'sd12345, 10'd77,   1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_SAMPLE, -16'sd9999, 10'd300,  1'b0, 8'sd0,   1'b0, 1'b0},
    '{REQ_START,  16'sd0,     10'd0,    1'b1, 8'sd0,   1'b0, 1'b0}
  };

  gyro_turn_p_controller dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .turn_rate     (turn_rate),
    .elapsed_ticks (elapsed_ticks),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_power   (drive_power),
    .turn_done     (turn_done),
    .within_band   (within_band)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Error to the setpoint in 2^-18 degree units
  function automatic wide_t angle_error();
    return (wide_t'(target_deg) <<< TGT_SHIFT) - wide_t'(angle);
  endfunction

  // Gain, truncate, clamp to the ceiling, then lift to the floor
  function automatic logic signed [POWER_W:0] power_for_error(wide_t err);
    logic [ANGLE_BITS+1:0] mag;
    logic [PROD_TB_W-1:0]  prod;
    logic [PROD_TB_W-1:0]  scaled;
    logic [POWER_W-1:0]    m;
    mag    = (err < 0) ? -err : err;
    prod   = PROD_TB_W'(mag) * PROD_TB_W'(gain);
    scaled = prod >> GAIN_SHIFT;
    if (scaled > PROD_TB_W'(ceil_mag)) m = ceil_mag;
    else if (scaled != 0 && scaled < PROD_TB_W'(floor_mag)) m = floor_mag;
    else m = scaled[POWER_W-1:0];
    return (err < 0) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Advance the turn state by one word and return the drive word it yields
  function automatic drive_word_t next_drive_word(logic req, logic signed [RATE_W-1:0] rate,
                                                  logic [TICK_W-1:0] ticks);
    wide_t       sum;
    wide_t       err;
    wide_t       lim_hi;
    wide_t       lim_lo;
    wide_t       band_w;
    logic        in_b;
    logic        out_b;
    logic        expired;
    drive_word_t w;
    w.power = '0;
    if (req == REQ_START) begin
      angle        = '0;
      settle_left  = '0;
      settle_armed = 1'b0;
      turn_settled = 1'b0;
      w.done       = 1'b0;
      w.in_band    = 1'b0;
      return w;
    end
    lim_hi = (wide_t'(1) <<< (ANGLE_BITS - 1)) - 1;
    lim_lo = -lim_hi - 1;
    sum = wide_t'(angle) + wide_t'(rate) * wide_t'(ticks);
    if (sum > lim_hi) sum = lim_hi;
    if (sum < lim_lo) sum = lim_lo;
    angle = sum[ANGLE_BITS-1:0];

    err    = angle_error();
    band_w = wide_t'(band) <<< BAND_SHIFT;
    in_b   = err < band_w && err > -band_w;
    out_b  = err > band_w || err < -band_w;

    // Count down only while armed; a fresh arm loads the full settle time
    if (settle_armed) begin
      settle_left = (settle_left > SETTLE_W'(ticks)) ? settle_left - SETTLE_W'(ticks) : '0;
    end
    if (in_b && !settle_armed) begin
      settle_left  = settle_len;
      settle_armed = 1'b1;
    end
    expired = settle_left == 0;

    if (out_b && expired && settle_armed) begin
      settle_armed = 1'b0;
      w.power      = power_for_error(err);
    end else if (in_b && expired && settle_armed) begin
      turn_settled = 1'b1;
    end else if (!in_b) begin
      w.power = power_for_error(err);
    end
    w.done    = turn_settled;
    w.in_band = in_b;
    return w;
  endfunction

  task automatic reset_mirror();
    target_deg   = 11'sd0;
    gain         = 12'd333;
    band         = 15'd1280;
    floor_mag    = 7'd60;
    ceil_mag     = 7'd65;
    settle_len   = 16'd512;
    angle        = '0;
    settle_left  = '0;
    settle_armed = 1'b0;
    turn_settled = 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [TICK_W-1:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return TICK_W'($urandom_range(1, 64));
    if (r < 95) return TICK_W'($urandom_range(65, 400));
    return TICK_W'($urandom_range(401, 1023));
  endfunction

  // Offer one word, hold it until taken, then queue its drive word
  task automatic send_word(input logic req, input logic signed [RATE_W-1:0] rate,
                           input logic [TICK_W-1:0] ticks);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    turn_rate     <= rate;
    elapsed_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drive_words.push_back(next_drive_word(req, rate, ticks));
    words_sent++;
  endtask

  // Stop offering and wait for every drive word to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drive_words.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Write all six registers back to back, holding the write enable high
  task automatic write_settings(input int tgt, input int gain_v, input int band_v,
                                input int floor_v, input int ceil_v, input int settle_v);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] vals [6];
    idx = '{REG_TARGET, REG_GAIN, REG_BAND, REG_FLOOR, REG_CEILING, REG_SETTLE};
    vals[0] = CFG_DATA_W'(tgt[TARGET_W-1:0]);
    vals[1] = CFG_DATA_W'(gain_v[GAIN_W-1:0]);
    vals[2] = CFG_DATA_W'(band_v[BAND_W-1:0]);
    vals[3] = CFG_DATA_W'(floor_v[POWER_W-1:0]);
    vals[4] = CFG_DATA_W'(ceil_v[POWER_W-1:0]);
    vals[5] = CFG_DATA_W'(settle_v[SETTLE_W-1:0]);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    target_deg = tgt[TARGET_W-1:0];
    gain       = gain_v[GAIN_W-1:0];
    band       = band_v[BAND_W-1:0];
    floor_mag  = floor_v[POWER_W-1:0];
    ceil_mag   = ceil_v[POWER_W-1:0];
    settle_len = settle_v[SETTLE_W-1:0];
  endtask

  // One turn: mostly samples steered toward the setpoint, a few noise words
  task automatic run_turn();
    int                       len;
    int                       nz;
    int                       pick;
    logic [TICK_W-1:0]        t;
    logic signed [RATE_W-1:0] r;
    wide_t                    want;
    len = $urandom_range(6, 45);
    if ($urandom_range(0, 9) != 0) send_word(REQ_START, RATE_W'($urandom), TICK_W'($urandom));
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(1'($urandom_range(0, 1)), RATE_W'($urandom), TICK_W'($urandom));
      end else begin
        t = pick_ticks();
        if (t == 0) begin
          r = RATE_W'($urandom);
        end else begin
          want = angle_error() / wide_t'(t);
          case ($urandom_range(0, 3))
            1: want = want / 2;
            2: want = want / 4;
            3: want = want + want / 2;
            default: ;
          endcase
          nz   = int'($urandom_range(0, 400)) - 200;
          want = want + wide_t'(nz);
          if (want > 32767) want = 32767;
          if (want < -32768) want = -32768;
          r = want[RATE_W-1:0];
        end
        send_word(REQ_SAMPLE, r, t);
      end
    end
    if ($urandom_range(0, 19) == 0) drain();
  endtask

  // Receiver: short and long stalls, runs with none, and the long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (long_hold_served != long_hold_asked) begin
        long_hold_served = long_hold_asked;
        stall_left       = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (receiver_quiet || run_left > 0) begin
        if (run_left > 0) run_left--;
        out_stall <= 1'b0;
      end else begin
        run_left   = $urandom_range(0, 8);
        stall_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        out_stall <= 1'b1;
      end
    end
  end

  // Compare each drive word with the oldest one pending
  always @(posedge clk) begin
    drive_word_t want_word;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drive_words.size() == 0) begin
        $error("unexpected drive word: drive_power %0d", drive_power);
        fail_count++;
      end else begin
        want_word = pending_drive_words.pop_front();
        if (drive_power !== want_word.power) begin
          $error("drive_power: expected %0d, got %0d", want_word.power, drive_power);
          fail_count++;
        end
        if (turn_done !== want_word.done) begin
          $error("turn_done: expected %0d, got %0d", want_word.done, turn_done);
          fail_count++;
        end
        if (within_band !== want_word.in_band) begin
          $error("within_band: expected %0d, got %0d", want_word.in_band, within_band);
          fail_count++;
        end
      end
    end
  end

  // End the run if neither side moves a word for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL gyro_turn_p_controller");
      $finish;
    end
  end

  initial begin
    drive_word_t typed_word;
    int          base;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    req_type      = REQ_START;
    turn_rate     = '0;
    elapsed_ticks = '0;
    reset_mirror();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the opening plan under the reset settings
    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_word(plan[i].req, plan[i].rate, plan[i].ticks);
      if (plan[i].typed) begin
        typed_word.power   = plan[i].power;
        typed_word.done    = plan[i].done;
        typed_word.in_band = plan[i].in_band;
        pending_drive_words[pending_drive_words.size()-1] = typed_word;
      end
    end

    // Full-scale samples back to back in both directions, without idling
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    send_word(REQ_START, '0, '0);
    repeat (FULL_RUN) send_word(REQ_SAMPLE, RATE_MAX, TICK_MAX);
    repeat (3) send_word(REQ_SAMPLE, RATE_MIN, TICK_MAX);
    send_word(REQ_START, '0, '0);
    repeat (FULL_RUN) send_word(REQ_SAMPLE, RATE_MIN, TICK_MAX);
    repeat (3) send_word(REQ_SAMPLE, RATE_MAX, TICK_MAX);
    drain();

    // Random turns, each phase under its own settings
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        write_settings(presets[p][0], presets[p][1], presets[p][2],
                       presets[p][3], presets[p][4], presets[p][5]);
      end else begin
        write_settings(int'($urandom_range(0, 2047)), int'($urandom_range(0, 4095)),
                       ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 4000))
                                                   : int'($urandom_range(0, 32767)),
                       int'($urandom_range(0, 127)), int'($urandom_range(0, 127)),
                       ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 600))
                                                   : int'($urandom_range(0, 65535)));
      end
      sender_quiet   = (p % 4 == 1) || (p % 4 == 3);
      receiver_quiet = (p % 4 >= 2);
      // Hold the receiver off while words keep coming, so input backs up
      if (p % 4 == 1) long_hold_asked++;
      base = words_sent;
      while (words_sent - base < PHASE_WORDS) run_turn();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS gyro_turn_p_controller");
    end else begin
      $display("FAIL gyro_turn_p_controller");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gtpc_pkg.sv
rtl/gyro_turn_p_controller.sv
test/gyro_turn_p_controller_tb.sv
